// ----- rtl/cgb_pkg.sv -----
// shared types and constants of the clipped glyph blitter
package cgb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_CLIP_X_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_Y_MIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_X_MAX = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_Y_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEST_STRIDE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DEST_BASE = 3'd5;

  localparam logic [7:0] FG_CODE = 8'd15;

  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;
  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic [10:0] x_min;
    logic [10:0] y_min;
    logic [10:0] x_max;
    logic [10:0] y_max;
  } cgb_clip_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  advance;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  color;
  } cgb_item_t;

endpackage

// ----- rtl/cgb_glyph_ctrl.sv -----
// glyph placement, clip tests and pixel walk, ending in the first result register
module cgb_glyph_ctrl import cgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             mode_i,
  input  logic [11:0]      glyph_x_i,
  input  logic [11:0]      glyph_bottom_y_i,
  input  logic [7:0]       glyph_width_i,
  input  logic [7:0]       glyph_height_i,
  input  logic [7:0]       text_color_i,
  input  logic [7:0]       pixel_value_i,
  input  cgb_clip_t        clip_i,
  input  logic             take_i,
  output logic             s1_valid_o,
  output cgb_item_t        s1_item_o
);

  logic [11:0] origin_x_q, origin_x_d;
  logic [12:0] top_y_q, top_y_d;
  logic [7:0]  cur_width_q, cur_width_d;
  logic [7:0]  cur_height_q, cur_height_d;
  logic [7:0]  col_count_q, col_count_d;
  logic [7:0]  row_count_q, row_count_d;
  logic [7:0]  draw_color_q, draw_color_d;
  logic        active_q, active_d;
  logic        s1_valid_q, s1_valid_d;
  cgb_item_t   s1_item_q, s1_item_d;

  logic signed [13:0] x_s, yb_s, w_s, h_s, top_s;
  logic signed [13:0] xmin_s, ymin_s, xmax_s, ymax_s;
  logic signed [13:0] px_s, py_s;
  logic               h_reject, v_ok, in_window, has_result;
  logic [8:0]         col_inc, row_inc;

  always_comb begin
    x_s    = $signed({{2{glyph_x_i[11]}}, glyph_x_i});
    yb_s   = $signed({{2{glyph_bottom_y_i[11]}}, glyph_bottom_y_i});
    w_s    = $signed({6'b0, glyph_width_i});
    h_s    = $signed({6'b0, glyph_height_i});
    xmin_s = $signed({3'b0, clip_i.x_min});
    ymin_s = $signed({3'b0, clip_i.y_min});
    xmax_s = $signed({3'b0, clip_i.x_max});
    ymax_s = $signed({3'b0, clip_i.y_max});
    top_s  = yb_s - h_s + 14'sd1;

    h_reject = (x_s > xmax_s) || (x_s <= xmin_s - w_s);
    v_ok     = !((top_s <= ymin_s - h_s) || (top_s > ymax_s)) &&
               (glyph_width_i != 8'd0) && (glyph_height_i != 8'd0);

    px_s = $signed({{2{origin_x_q[11]}}, origin_x_q}) + $signed({6'b0, col_count_q});
    py_s = $signed({top_y_q[12], top_y_q}) + $signed({6'b0, row_count_q});
    in_window = (px_s >= xmin_s) && (px_s <= xmax_s) &&
                (py_s >= ymin_s) && (py_s <= ymax_s);

    col_inc = {1'b0, col_count_q} + 9'd1;
    row_inc = {1'b0, row_count_q} + 9'd1;

    origin_x_d   = origin_x_q;
    top_y_d      = top_y_q;
    cur_width_d  = cur_width_q;
    cur_height_d = cur_height_q;
    col_count_d  = col_count_q;
    row_count_d  = row_count_q;
    draw_color_d = draw_color_q;
    active_d     = active_q;
    has_result   = 1'b0;
    s1_item_d    = '0;

    if (accept_i) begin
      if (mode_i == MODE_BEGIN) begin
        has_result        = 1'b1;
        s1_item_d.kind    = KIND_ADVANCE;
        s1_item_d.advance = h_reject ? 8'd0 : glyph_width_i;
        active_d          = 1'b0;
        if (!h_reject && v_ok) begin
          origin_x_d   = glyph_x_i;
          top_y_d      = top_s[12:0];
          cur_width_d  = glyph_width_i;
          cur_height_d = glyph_height_i;
          draw_color_d = text_color_i;
          col_count_d  = 8'd0;
          row_count_d  = 8'd0;
          active_d     = 1'b1;
        end
      end else if (active_q) begin
        if (pixel_value_i == FG_CODE && in_window) begin
          has_result      = 1'b1;
          s1_item_d.kind  = KIND_WRITE;
          s1_item_d.x     = px_s[10:0];
          s1_item_d.y     = py_s[10:0];
          s1_item_d.color = draw_color_q;
        end
        // row-major walk, glyph ends after its last pixel
        if (col_inc >= {1'b0, cur_width_q}) begin
          col_count_d = 8'd0;
          if (row_inc >= {1'b0, cur_height_q}) begin
            row_count_d = 8'd0;
            active_d    = 1'b0;
          end else begin
            row_count_d = row_inc[7:0];
          end
        end else begin
          col_count_d = col_inc[7:0];
        end
      end
    end

    if (has_result) begin
      s1_valid_d = 1'b1;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      top_y_q      <= '0;
      cur_width_q  <= '0;
      cur_height_q <= '0;
      col_count_q  <= '0;
      row_count_q  <= '0;
      draw_color_q <= '0;
      active_q     <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      origin_x_q   <= origin_x_d;
      top_y_q      <= top_y_d;
      cur_width_q  <= cur_width_d;
      cur_height_q <= cur_height_d;
      col_count_q  <= col_count_d;
      row_count_q  <= row_count_d;
      draw_color_q <= draw_color_d;
      active_q     <= active_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      s1_item_q <= s1_item_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

// ----- rtl/cgb_addr_out.sv -----
// address computation and output register
module cgb_addr_out import cgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s1_valid_i,
  input  cgb_item_t   s1_item_i,
  input  logic [12:0] dest_stride_i,
  input  logic [23:0] dest_base_i,
  input  logic        out_ready_i,
  output logic        take_o,
  output logic        out_valid_o,
  output logic        kind_o,
  output logic [7:0]  advance_o,
  output logic [10:0] pixel_x_o,
  output logic [10:0] pixel_y_o,
  output logic [23:0] address_o,
  output logic [7:0]  color_o
);

  logic        out_valid_q, out_valid_d;
  logic        load;
  logic [23:0] row_offset, address_d;
  cgb_item_t   item_q;
  logic [23:0] address_q;

  assign take_o = !out_valid_q || out_ready_i;
  assign load   = take_o && s1_valid_i;

  always_comb begin
    row_offset = {13'b0, s1_item_i.y} * {11'b0, dest_stride_i};
    address_d  = '0;
    if (s1_item_i.kind == KIND_WRITE) begin
      address_d = dest_base_i + row_offset + {13'b0, s1_item_i.x};
    end
    out_valid_d = take_o ? s1_valid_i : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q    <= s1_item_i;
      address_q <= address_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = item_q.kind;
  assign advance_o   = item_q.advance;
  assign pixel_x_o   = item_q.x;
  assign pixel_y_o   = item_q.y;
  assign address_o   = address_q;
  assign color_o     = item_q.color;

endmodule

// ----- rtl/clipped_glyph_blitter_top.sv -----
// top level of the clipped glyph blitter
// Draws transparent glyphs into a byte-per-pixel framebuffer, clipped to a window.
// Input channel (in_valid_i / in_ready_o): a begin item (mode 0) places a glyph and
// always yields one advance result; pixel items (mode 1) follow in row-major order
// and yield one write for each foreground pixel (code 15) inside the window.
// Output channel (out_valid_o / out_ready_i): advance results and pixel writes in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i;
// indexes 0..5 are clip x min, clip y min, clip x max, clip y max, stride, base.
// Write configuration only while no item is in flight.
// Throughput: one item per cycle while out_ready_i stays high. A result passes through
// the clip stage register and then the address register that holds the 11x13 row
// multiply.
// When the receiver stalls, the two result registers fill and then in_ready_o drops;
// items that produce no result never occupy a register.
// Reset clears both result registers and the glyph state, and loads the window
// 0..639 by 0..479, stride 640 and base 0.
module clipped_glyph_blitter_top import cgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [11:0]         glyph_x_i,
  input  logic [11:0]         glyph_bottom_y_i,
  input  logic [7:0]          glyph_width_i,
  input  logic [7:0]          glyph_height_i,
  input  logic [7:0]          text_color_i,
  input  logic [7:0]          pixel_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [7:0]          advance_o,
  output logic [10:0]         pixel_x_o,
  output logic [10:0]         pixel_y_o,
  output logic [23:0]         address_o,
  output logic [7:0]          color_o
);

  cgb_clip_t   clip_q;
  logic [12:0] dest_stride_q;
  logic [23:0] dest_base_q;
  logic        s1_valid, take, accept;
  cgb_item_t   s1_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q.x_min  <= 11'd0;
      clip_q.y_min  <= 11'd0;
      clip_q.x_max  <= 11'd639;
      clip_q.y_max  <= 11'd479;
      dest_stride_q <= 13'd640;
      dest_base_q   <= 24'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLIP_X_MIN:  clip_q.x_min  <= cfg_data_i[10:0];
        CFG_CLIP_Y_MIN:  clip_q.y_min  <= cfg_data_i[10:0];
        CFG_CLIP_X_MAX:  clip_q.x_max  <= cfg_data_i[10:0];
        CFG_CLIP_Y_MAX:  clip_q.y_max  <= cfg_data_i[10:0];
        CFG_DEST_STRIDE: dest_stride_q <= cfg_data_i[12:0];
        CFG_DEST_BASE:   dest_base_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // the first stage frees up whenever the output stage takes its item
  assign in_ready_o = !s1_valid || take;
  assign accept     = in_valid_i && in_ready_o;

  cgb_glyph_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .glyph_x_i        (glyph_x_i),
    .glyph_bottom_y_i (glyph_bottom_y_i),
    .glyph_width_i    (glyph_width_i),
    .glyph_height_i   (glyph_height_i),
    .text_color_i     (text_color_i),
    .pixel_value_i    (pixel_value_i),
    .clip_i           (clip_q),
    .take_i           (take),
    .s1_valid_o       (s1_valid),
    .s1_item_o        (s1_item)
  );

  cgb_addr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_item_i     (s1_item),
    .dest_stride_i (dest_stride_q),
    .dest_base_i   (dest_base_q),
    .out_ready_i   (out_ready_i),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .advance_o     (advance_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .address_o     (address_o),
    .color_o       (color_o)
  );

endmodule
